@@ rtl/stepper_wave_drive_sequencer_macros.svh @@
// Assertion helpers shared by the sequencer RTL.
// Each helper is clocked on i_clk and disabled while i_rst_n is low.
`ifndef STEPPER_WAVE_DRIVE_SEQUENCER_MACROS_SVH
`define STEPPER_WAVE_DRIVE_SEQUENCER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SWDS_ASSERT_SAME(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error("sequencer check failed");

// Check that a condition implies a consequence in the following cycle.
`define SWDS_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error("sequencer check failed");

`endif

@@ rtl/swds_pkg.sv @@
// ----------------------------------------------------------------------------
// swds_pkg
// Shared types, constants and helpers of the stepper wave drive sequencer.
// ----------------------------------------------------------------------------
package swds_pkg;

    // Width of the four-step cycle counter
    localparam int COUNT_BITS = 16;

    // Input field widths
    localparam int ANGLE_BITS = 16;
    localparam int HOLD_BITS  = 16;

    // floor(64 * angle / 45) as (angle * RECIP_M) >> RECIP_SHIFT, exact for 16-bit angles
    localparam int RECIP_BITS  = 23;
    localparam int RECIP_SHIFT = 22;
    localparam logic [RECIP_BITS-1:0] RECIP_M = 23'd5965233;
    localparam int PROD_BITS   = ANGLE_BITS + RECIP_BITS;
    localparam int QUOT_BITS   = 17;
    localparam int CMP_BITS    = (COUNT_BITS > QUOT_BITS) ? COUNT_BITS : QUOT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int PTR_BITS   = 1;
    localparam int CNT_BITS   = 2;

    typedef enum logic [1:0] {
        OP_MOVE   = 2'd0,
        OP_STOP   = 2'd1,
        OP_TICK   = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        CMD_MOVE,
        CMD_MOVE_NULL,
        CMD_STOP,
        CMD_TICK,
        CMD_NONE
    } t_cmd_kind;

    // Classified request handed from front to back
    typedef struct packed {
        t_cmd_kind              kind;
        logic                   fwd;
        logic [COUNT_BITS-1:0]  cycles_m1;
        logic [HOLD_BITS-1:0]   hold_reload;
    } t_cmd_entry;

    // Result of one request
    typedef struct packed {
        logic [3:0] phase_pattern;
        logic       busy_res;
        logic       move_done;
        logic       command_rejected;
    } t_result;

    // One-low wave pattern for step position 0..3
    function automatic logic [3:0] wave_pattern(input logic [1:0] pos);
        logic [3:0] pat;
        unique case (pos)
            2'd0: pat = 4'h7;
            2'd1: pat = 4'hB;
            2'd2: pat = 4'hD;
            2'd3: pat = 4'hE;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/swds_front.sv @@
// ----------------------------------------------------------------------------
// swds_front
// Classifies incoming requests and precomputes the move cycle count.
// ----------------------------------------------------------------------------
module swds_front (
    input  logic [1:0]                     i_opcode,
    input  logic                           i_turn_forward,
    input  logic [swds_pkg::ANGLE_BITS-1:0] i_angle_degrees,
    input  logic [swds_pkg::HOLD_BITS-1:0]  i_step_hold_ms,
    output swds_pkg::t_cmd_entry           o_entry
);
    import swds_pkg::*;

    logic [PROD_BITS-1:0]  prod;
    logic [QUOT_BITS-1:0]  quot;
    logic [CMP_BITS-1:0]   quot_ext;
    logic [COUNT_BITS-1:0] cycles;
    t_cmd_kind             kind;

    // Scale angle to cycles by reciprocal multiply
    assign prod     = PROD_BITS'(i_angle_degrees) * PROD_BITS'(RECIP_M);
    assign quot     = prod[RECIP_SHIFT +: QUOT_BITS];
    assign quot_ext = CMP_BITS'(quot);

    // Saturate at counter max; nonzero angles always give at least one cycle
    assign cycles = (quot_ext > CMP_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(quot_ext);

    // Decode request kind
    always_comb begin
        unique case (t_opcode'(i_opcode))
            OP_MOVE:   kind = (i_angle_degrees == '0) ? CMD_MOVE_NULL : CMD_MOVE;
            OP_STOP:   kind = CMD_STOP;
            OP_TICK:   kind = CMD_TICK;
            OP_UNUSED: kind = CMD_NONE;
            default:   kind = CMD_NONE;
        endcase
    end

    always_comb begin
        o_entry.kind        = kind;
        o_entry.fwd         = i_turn_forward;
        o_entry.cycles_m1   = cycles - COUNT_BITS'(1);
        o_entry.hold_reload = (i_step_hold_ms == '0) ? HOLD_BITS'(1) : i_step_hold_ms;
    end

endmodule

@@ rtl/swds_fifo.sv @@
// ----------------------------------------------------------------------------
// swds_fifo
// Short request queue decoupling the classifier from the executor.
// ----------------------------------------------------------------------------
module swds_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  swds_pkg::t_cmd_entry i_wr_data,
    output logic                 o_full,
    input  logic                 i_rd,
    output logic                 o_valid,
    output swds_pkg::t_cmd_entry o_rd_data
);
    import swds_pkg::*;

    t_cmd_entry          r_mem [FIFO_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_BITS-1:0] r_count, n_count;
    logic                do_wr, do_rd;

    assign o_full    = (r_count == CNT_BITS'(FIFO_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && o_valid;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (do_rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (do_rd && !do_wr) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store request payload
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

@@ rtl/swds_back.sv @@
// ----------------------------------------------------------------------------
// swds_back
// Executes queued requests against the stepper state and registers results.
// ----------------------------------------------------------------------------
module swds_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  swds_pkg::t_cmd_entry i_entry,
    output logic                 o_take,
    input  logic                 i_pop,
    output logic                 o_res_valid,
    output swds_pkg::t_result    o_result
);
    import swds_pkg::*;

    logic [3:0]            r_drive, n_drive;
    logic [1:0]            r_pos, n_pos;
    logic [COUNT_BITS-1:0] r_cycles, n_cycles;
    logic [1:0]            r_steps, n_steps;
    logic [HOLD_BITS-1:0]  r_hold, n_hold;
    logic [HOLD_BITS-1:0]  r_reload, n_reload;
    logic                  r_fwd, n_fwd;
    logic                  r_moving, n_moving;
    logic                  r_out_valid, n_out_valid;
    t_result               r_result, n_result;
    logic [HOLD_BITS-1:0]  hold_dec;
    logic                  done;
    logic                  rejected;

    // Execute when the result slot is free or being drained
    assign o_take      = i_valid && (!r_out_valid || i_pop);
    assign o_res_valid = r_out_valid;
    assign o_result    = r_result;
    assign hold_dec    = (r_hold == '0) ? '0 : r_hold - HOLD_BITS'(1);

    // Next stepper state
    always_comb begin
        n_drive  = r_drive;
        n_pos    = r_pos;
        n_cycles = r_cycles;
        n_steps  = r_steps;
        n_hold   = r_hold;
        n_reload = r_reload;
        n_fwd    = r_fwd;
        n_moving = r_moving;
        done     = 1'b0;
        rejected = 1'b0;
        if (o_take) begin
            unique case (i_entry.kind)
                CMD_MOVE: begin
                    if (r_moving) begin
                        rejected = 1'b1;
                    end else begin
                        n_cycles = i_entry.cycles_m1;
                        n_steps  = 2'd3;
                        n_fwd    = i_entry.fwd;
                        n_pos    = i_entry.fwd ? 2'd0 : 2'd3;
                        n_reload = i_entry.hold_reload;
                        n_moving = 1'b1;
                        n_drive  = wave_pattern(i_entry.fwd ? 2'd0 : 2'd3);
                        n_hold   = i_entry.hold_reload;
                    end
                end
                CMD_MOVE_NULL: begin
                    rejected = r_moving;
                end
                CMD_STOP: begin
                    n_drive  = 4'h0;
                    n_moving = 1'b0;
                    n_cycles = '0;
                    n_steps  = 2'd0;
                    n_hold   = '0;
                end
                CMD_TICK: begin
                    if (r_moving) begin
                        n_hold = hold_dec;
                        if (hold_dec == '0) begin
                            priority if (r_steps != 2'd0) begin
                                n_steps = r_steps - 2'd1;
                                n_pos   = r_fwd ? r_pos + 2'd1 : r_pos - 2'd1;
                                n_drive = wave_pattern(r_fwd ? r_pos + 2'd1 : r_pos - 2'd1);
                                n_hold  = r_reload;
                            end else if (r_cycles != '0) begin
                                n_cycles = r_cycles - COUNT_BITS'(1);
                                n_steps  = 2'd3;
                                n_pos    = r_fwd ? 2'd0 : 2'd3;
                                n_drive  = wave_pattern(r_fwd ? 2'd0 : 2'd3);
                                n_hold   = r_reload;
                            end else begin
                                n_moving = 1'b0;
                                done     = 1'b1;
                            end
                        end
                    end
                end
                CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // Hold or refill the result slot
    always_comb begin
        n_out_valid = r_out_valid;
        n_result    = r_result;
        if (o_take) begin
            n_out_valid               = 1'b1;
            n_result.phase_pattern    = n_drive;
            n_result.busy_res         = n_moving;
            n_result.move_done        = done;
            n_result.command_rejected = rejected;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive     <= 4'h0;
            r_pos       <= 2'd0;
            r_cycles    <= '0;
            r_steps     <= 2'd0;
            r_hold      <= '0;
            r_reload    <= '0;
            r_fwd       <= 1'b0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_drive     <= n_drive;
            r_pos       <= n_pos;
            r_cycles    <= n_cycles;
            r_steps     <= n_steps;
            r_hold      <= n_hold;
            r_reload    <= n_reload;
            r_fwd       <= n_fwd;
            r_moving    <= n_moving;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

endmodule

@@ rtl/stepper_wave_drive_sequencer.sv @@
// Path: an accepted request is written into the request queue, then executed into the registered result slot.
// Throughput: one request per cycle; the two-entry request queue and the result
//   register let input and output stall independently.
// Reset: synchronous, active low; phases off, idle, queue and result slot empty.
// ----------------------------------------------------------------------------
// stepper_wave_drive_sequencer
// Four-phase wave drive sequencer for a unipolar stepper: move, stop and tick.
// ----------------------------------------------------------------------------
`include "stepper_wave_drive_sequencer_macros.svh"

module stepper_wave_drive_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [1:0]                      i_opcode,
    input  logic                            i_turn_forward,
    input  logic [swds_pkg::ANGLE_BITS-1:0] i_angle_degrees,
    input  logic [swds_pkg::HOLD_BITS-1:0]  i_step_hold_ms,
    output logic                            empty,
    input  logic                            pop,
    output logic [3:0]                      o_phase_pattern,
    output logic                            o_busy_res,
    output logic                            o_move_done,
    output logic                            o_command_rejected
);
    import swds_pkg::*;

    t_cmd_entry front_entry;
    t_cmd_entry q_entry;
    logic       q_valid;
    logic       q_take;
    logic       res_valid;
    t_result    result;

    // Classify incoming request
    swds_front u_front (
        .i_opcode        (i_opcode),
        .i_turn_forward  (i_turn_forward),
        .i_angle_degrees (i_angle_degrees),
        .i_step_hold_ms  (i_step_hold_ms),
        .o_entry         (front_entry)
    );

    // Queue classified requests
    swds_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_entry),
        .o_full    (full),
        .i_rd      (q_take),
        .o_valid   (q_valid),
        .o_rd_data (q_entry)
    );

    // Execute requests and hold results
    swds_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_entry     (q_entry),
        .o_take      (q_take),
        .i_pop       (pop),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    assign empty              = !res_valid;
    assign o_phase_pattern    = result.phase_pattern;
    assign o_busy_res         = result.busy_res;
    assign o_move_done        = result.move_done;
    assign o_command_rejected = result.command_rejected;

    // A finished move is no longer busy
    `SWDS_ASSERT_SAME(a_done_not_busy, !empty && o_move_done, !o_busy_res)
    // A rejected move leaves the running move busy
    `SWDS_ASSERT_SAME(a_reject_busy, !empty && o_command_rejected, o_busy_res)
    // While moving exactly one phase is low
    `SWDS_ASSERT_SAME(a_busy_wave, !empty && o_busy_res, $onehot(~o_phase_pattern))
    // A queued request reaches the output once the result slot drains
    `SWDS_ASSERT_NEXT(a_queue_drains, full && empty, !empty)

endmodule
